>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and controller/datapath interface types for the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Compare codes
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic form;
        logic gcd_step;
        logic shift_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } rau_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic finish_early;
        logic gcd_done;
        logic k_zero;
        logic div_done;
    } rau_stat_t;

endpackage

>>> design/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Operand capture, shared multiplier, signed sum, binary gcd, gcd scaling,
// bit-serial dual divider and result register.
// ----------------------------------------------------------------------------
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rau_cmd_t          cmd,
    output rau_stat_t         stat,
    input  logic [2:0]        in_op,
    input  logic [31:0]       in_a_num,
    input  logic [31:0]       in_a_den,
    input  logic [31:0]       in_b_num,
    input  logic [31:0]       in_b_den,
    output logic [31:0]       res_num,
    output logic [30:0]       res_den,
    output logic [1:0]        order,
    output logic [1:0]        status
);

    localparam int W   = OPERAND_WIDTH;
    localparam int MW  = 2 * W;
    localparam int PW  = 2 * W + 1;
    localparam int EW  = (PW > 32) ? PW : 32;
    localparam int KW  = $clog2(PW + 1);

    // Operand registers
    logic [2:0]    op_reg;
    logic [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic          aneg_reg, bneg_reg, err_reg;

    // Products and working registers
    logic [MW-1:0] p_reg, q_reg, d_reg;
    logic [PW-1:0] n_reg, dd_reg, x_reg, y_reg, rn_reg, rd_reg;
    logic          nneg_reg;
    logic [1:0]    ord_reg;
    logic [KW-1:0] k_reg, cnt_reg;

    // Output registers
    logic [31:0]   res_num_reg;
    logic [30:0]   res_den_reg;
    logic [1:0]    order_reg, status_reg;

    // Operand decode at W bits
    logic [W-1:0]  v_an, v_ad, v_bn, v_bd, m_an, m_ad, m_bn, m_bd;
    assign v_an = in_a_num[W-1:0];
    assign v_ad = in_a_den[W-1:0];
    assign v_bn = in_b_num[W-1:0];
    assign v_bd = in_b_den[W-1:0];
    assign m_an = v_an[W-1] ? (~v_an + W'(1)) : v_an;
    assign m_ad = v_ad[W-1] ? (~v_ad + W'(1)) : v_ad;
    assign m_bn = v_bn[W-1] ? (~v_bn + W'(1)) : v_bn;
    assign m_bd = v_bd[W-1] ? (~v_bd + W'(1)) : v_bd;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            an_reg   <= m_an;
            ad_reg   <= m_ad;
            bn_reg   <= m_bn;
            bd_reg   <= m_bd;
            aneg_reg <= v_an[W-1] ^ v_ad[W-1];
            bneg_reg <= v_bn[W-1] ^ v_bd[W-1];
            err_reg  <= (in_op > OP_CMP) || (m_ad == '0) || (m_bd == '0)
                        || ((in_op == OP_DIV) && (m_bn == '0));
        end
    end

    // Shared multiplier, one product per cycle
    logic [W-1:0]  mul_a, mul_b;
    logic [MW-1:0] prod;
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        if (cmd.mul1)
        begin
            mul_a = an_reg;
            mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
        end
        else if (cmd.mul2)
        begin
            mul_a = bn_reg;
            mul_b = ad_reg;
        end
        else if (cmd.mul3)
        begin
            mul_a = ad_reg;
            mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
        end
    end
    assign prod = MW'(mul_a) * MW'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
            p_reg <= prod;
        if (cmd.mul2)
            q_reg <= prod;
        if (cmd.mul3)
            d_reg <= prod;
    end

    // Signed numerator and compare order
    logic [PW-1:0] pe, qe, sum_mag;
    logic          qneg, sum_neg, lneg, rneg;
    logic [1:0]    ord_next;
    always_comb
    begin
        pe   = PW'(p_reg);
        qe   = PW'(q_reg);
        qneg = (op_reg == OP_SUB) ? ~bneg_reg : bneg_reg;
        if (aneg_reg == qneg)
        begin
            sum_mag = pe + qe;
            sum_neg = aneg_reg;
        end
        else if (pe >= qe)
        begin
            sum_mag = pe - qe;
            sum_neg = aneg_reg;
        end
        else
        begin
            sum_mag = qe - pe;
            sum_neg = qneg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;

        lneg = aneg_reg && (p_reg != '0);
        rneg = bneg_reg && (q_reg != '0);
        if (lneg != rneg)
            ord_next = lneg ? ORD_LESS : ORD_GREATER;
        else if (p_reg == q_reg)
            ord_next = ORD_EQUAL;
        else if (lneg)
            ord_next = (p_reg > q_reg) ? ORD_LESS : ORD_GREATER;
        else
            ord_next = (p_reg < q_reg) ? ORD_LESS : ORD_GREATER;
    end

    // Binary gcd step
    logic [PW-1:0] x_next, y_next, xy_diff, yx_diff;
    logic          k_inc;
    assign xy_diff = x_reg - y_reg;
    assign yx_diff = y_reg - x_reg;
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        k_inc  = 1'b0;
        if (!x_reg[0] && !y_reg[0])
        begin
            x_next = x_reg >> 1;
            y_next = y_reg >> 1;
            k_inc  = 1'b1;
        end
        else if (!x_reg[0])
            x_next = x_reg >> 1;
        else if (!y_reg[0])
            y_next = y_reg >> 1;
        else if (x_reg >= y_reg)
            x_next = xy_diff >> 1;
        else
            y_next = yx_diff >> 1;
    end

    // Restoring divide step, numerator and denominator share the divisor
    logic [PW:0]   tn, td;
    logic          qn, qd;
    logic [PW-1:0] rn_next, rd_next;
    always_comb
    begin
        tn = {rn_reg, n_reg[PW-1]};
        td = {rd_reg, dd_reg[PW-1]};
        qn = tn >= {1'b0, x_reg};
        qd = td >= {1'b0, x_reg};
        rn_next = qn ? PW'(tn - {1'b0, x_reg}) : tn[PW-1:0];
        rd_next = qd ? PW'(td - {1'b0, x_reg}) : td[PW-1:0];
    end

    // Working register updates
    always_ff @(posedge clk)
    begin
        if (cmd.form)
        begin
            if ((op_reg == OP_ADD) || (op_reg == OP_SUB))
            begin
                n_reg    <= sum_mag;
                nneg_reg <= sum_neg;
            end
            else
            begin
                n_reg    <= PW'(p_reg);
                nneg_reg <= aneg_reg ^ bneg_reg;
            end
            x_reg   <= ((op_reg == OP_ADD) || (op_reg == OP_SUB)) ? sum_mag : PW'(p_reg);
            dd_reg  <= PW'(d_reg);
            y_reg   <= PW'(d_reg);
            k_reg   <= '0;
            ord_reg <= ord_next;
        end
        else if (cmd.gcd_step)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (k_inc)
                k_reg <= k_reg + KW'(1);
        end
        else if (cmd.shift_step)
        begin
            x_reg <= x_reg << 1;
            k_reg <= k_reg - KW'(1);
        end
        else if (cmd.div_init)
        begin
            rn_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= KW'(PW);
        end
        else if (cmd.div_step)
        begin
            rn_reg  <= rn_next;
            rd_reg  <= rd_next;
            n_reg   <= {n_reg[PW-2:0], qn};
            dd_reg  <= {dd_reg[PW-2:0], qd};
            cnt_reg <= cnt_reg - KW'(1);
        end
    end

    // Result formatting: quotients sit in n_reg and dd_reg
    localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);
    logic          ovf;
    logic [EW-1:0] num_ext, den_ext;
    assign ovf = ((dd_reg >> (W - 1)) != '0)
                 || (nneg_reg ? (n_reg > HALF) : ((n_reg >> (W - 1)) != '0));
    assign num_ext = nneg_reg ? (~EW'(n_reg) + EW'(1)) : EW'(n_reg);
    assign den_ext = EW'(dd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_num_reg <= '0;
            res_den_reg <= '0;
            order_reg   <= ORD_LESS;
            status_reg  <= ST_OK;
        end
        else if (cmd.out_load)
        begin
            res_num_reg <= '0;
            res_den_reg <= '0;
            order_reg   <= ORD_LESS;
            status_reg  <= ST_OK;
            if (err_reg)
                status_reg <= ST_ZERO_DEN;
            else if (op_reg == OP_CMP)
                order_reg <= ord_reg;
            else if (n_reg == '0)
                res_den_reg <= 31'd1;
            else if (ovf)
                status_reg <= ST_OVERFLOW;
            else
            begin
                res_num_reg <= num_ext[31:0];
                res_den_reg <= den_ext[30:0];
            end
        end
    end

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign order   = order_reg;
    assign status  = status_reg;

    // Status to controller
    assign stat.finish_early = err_reg || (op_reg == OP_CMP) || (n_reg == '0);
    assign stat.gcd_done     = (x_reg == y_reg);
    assign stat.k_zero       = (k_reg == '0);
    assign stat.div_done     = (cnt_reg == '0);

endmodule

>>> design/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational arithmetic unit: multiply, form, gcd, scale,
// divide, then hand the result to the output register.
// ----------------------------------------------------------------------------
module rau_ctrl
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output rau_cmd_t  cmd,
    input  rau_stat_t stat
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_MUL3  = 9'b000001000,
        S_FORM  = 9'b000010000,
        S_GCD   = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_DONE  = 9'b100000000
    } rau_state_t;

    rau_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (stat.finish_early)
                    state_next = S_DONE;
                else if (stat.gcd_done)
                    state_next = S_SHIFT;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_SHIFT:
            begin
                if (stat.k_zero)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_DONE;
                else
                    cmd.div_step = 1'b1;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> design/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Exact add, subtract, multiply, divide and compare of two signed rationals
// with gcd reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave beat: s_tdata carries a_num, a_den, b_num, b_den; s_tuser the
//   opcode. Master beat: m_tdata carries res_num, res_den, order; m_tuser
//   the status code. One result beat per input beat, in order.
//   One item is in work at a time; s_tready is high only while idle.
//   Steps: the multiplies, a form step, then binary gcd over
//   2*OPERAND_WIDTH+1 bit values, a shift step per common factor of two
//   to scale the gcd, and a bit-serial divide over the same width. Errors,
//   compare and zero results skip gcd and divide and go straight to the
//   output register.
//   The result sits in an output register, so a new beat is taken while it
//   waits; if the receiver stalls, the next finished result waits inside
//   until the register drains.
//   Reset clears the sequencer and the output valid; no result is pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  logic [2:0]   s_tuser,   // op[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // res_num[31:0], res_den[62:32], order[64:63], zero pad
    output logic [1:0]   m_tuser    // status[1:0]
);

    rau_cmd_t    cmd;
    rau_stat_t   stat;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;

    rau_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_op    (s_tuser),
        .in_a_num (s_tdata[31:0]),
        .in_a_den (s_tdata[63:32]),
        .in_b_num (s_tdata[95:64]),
        .in_b_den (s_tdata[127:96]),
        .res_num  (res_num),
        .res_den  (res_den),
        .order    (order),
        .status   (status)
    );

    // Pack result beat
    assign m_tdata = {7'd0, order, res_den, res_num};
    assign m_tuser = status;

endmodule
